[hw/rtl/mmcs_pkg.sv]
// Shared types and codes for the min/max contrast stretch block.
// Used by the divider and the top level; depends on nothing else.
package mmcs_pkg;

  // Item kinds carried in in_tuser[0].
  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_MAP     = 1'b1;

  // Status that the divider reports to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } mmcs_div_stat_t;

endpackage

[hw/rtl/mmcs_div.sv]
// Iterative restoring divider that computes 2^PIXEL_BITS / divisor, one quotient bit per cycle.
// Depends on mmcs_pkg for the status struct.
module mmcs_div #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [PIXEL_BITS-1:0]      divisor,
  output mmcs_pkg::mmcs_div_stat_t   stat,
  output logic [PIXEL_BITS:0]        quotient
);
  import mmcs_pkg::*;

  localparam int CNT_W = $clog2(PIXEL_BITS + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [PIXEL_BITS-1:0] rem_r, rem_nxt;
  logic [PIXEL_BITS:0]   dvd_r, dvd_nxt;
  logic [PIXEL_BITS:0]   quo_r, quo_nxt;
  logic [PIXEL_BITS:0]   trial;
  logic [PIXEL_BITS:0]   diff;
  logic                  fits;

  // One restoring step: bring down the next dividend bit and try to subtract.
  assign trial = {rem_r, dvd_r[PIXEL_BITS]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    if (start) begin
      // The dividend is a one followed by PIXEL_BITS zeros.
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(PIXEL_BITS);
      rem_nxt  = '0;
      dvd_nxt  = {1'b1, {PIXEL_BITS{1'b0}}};
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[PIXEL_BITS-1:0] : trial[PIXEL_BITS-1:0];
      dvd_nxt = {dvd_r[PIXEL_BITS-1:0], 1'b0};
      quo_nxt = {quo_r[PIXEL_BITS-1:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control flops reset; the datapath is loaded on start.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

`ifndef SYNTHESIS
  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider signalled done while still busy");
  a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && !done_r)
    else $error("divider did not start after a start request");
  a_quotient_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && $past(divisor) != '0) |-> quo_r != '0)
    else $error("divider produced a zero scale for a nonzero range");
`endif

endmodule

[hw/rtl/min_max_contrast_stretch_unit.sv]
// Min/max contrast stretch: measure items track the running minimum and maximum, map items are
// scaled by 2^PIXEL_BITS / (max - min), worked out by the iterative divider and latched.
// Measure item: in_tready stays high. Map item: product registered in ST_MUL, result registered
// in ST_OUT once the result register is free, then back to ST_IDLE; in_tready is low meanwhile.
// The first map item after a measurement waits in ST_DIV for the divider if the range is positive.
// Reset (synchronous, rst_n low): minimum all ones, maximum zero, scale cleared, no result pending.
module min_max_contrast_stretch_unit #(
  parameter int  PIXEL_BITS = 8,
  localparam int TDATA_W    = ((PIXEL_BITS + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // pixel
  input  logic [1:0]         in_tuser,   // cmd, frame_start
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // pixel_out
  output logic               out_tuser   // range_error
);
  import mmcs_pkg::*;

  localparam int PROD_W = 2 * PIXEL_BITS + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [PIXEL_BITS-1:0] low_r, low_nxt;
  logic [PIXEL_BITS-1:0] high_r, high_nxt;
  logic [PIXEL_BITS:0]   scale_r, scale_nxt;
  logic                  scale_valid_r, scale_valid_nxt;
  logic [PIXEL_BITS-1:0] pix_r, pix_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic                  below_r, below_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [PIXEL_BITS-1:0] out_pix_r, out_pix_nxt;
  logic                  out_err_r, out_err_nxt;

  logic                  in_acc;
  logic                  in_cmd;
  logic                  in_start;
  logic [PIXEL_BITS-1:0] in_pix;
  logic                  div_start;
  mmcs_div_stat_t        div_stat;
  logic [PIXEL_BITS:0]   div_quo;
  logic [PIXEL_BITS-1:0] diff;
  logic                  sat;
  logic [PIXEL_BITS-1:0] mapped;

  assign in_acc   = in_tvalid && in_tready;
  assign in_cmd   = in_tuser[0];
  assign in_start = in_tuser[1];
  assign in_pix   = in_tdata[PIXEL_BITS-1:0];

  // The scale is only divided out when the range is positive.
  assign div_start = in_acc && (in_cmd == CMD_MAP) && !scale_valid_r && (high_r > low_r);

  mmcs_div #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (high_r - low_r),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // Product terms and saturation.
  assign diff   = pix_r - low_r;
  assign sat    = |prod_r[PROD_W-1:PIXEL_BITS];
  assign mapped = below_r ? '0 : (sat ? {PIXEL_BITS{1'b1}} : prod_r[PIXEL_BITS-1:0]);

  // Sequencer: measure, divide, multiply, deliver.
  always_comb begin
    state_nxt       = state_r;
    low_nxt         = low_r;
    high_nxt        = high_r;
    scale_nxt       = scale_r;
    scale_valid_nxt = scale_valid_r;
    pix_nxt         = pix_r;
    prod_nxt        = prod_r;
    below_nxt       = below_r;
    out_tvalid_nxt  = out_tvalid_r && !out_tready;
    out_pix_nxt     = out_pix_r;
    out_err_nxt     = out_err_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_MEASURE) begin
            if (in_start) begin
              low_nxt  = in_pix;
              high_nxt = in_pix;
            end else begin
              if (in_pix < low_r) low_nxt = in_pix;
              if (in_pix > high_r) high_nxt = in_pix;
            end
            scale_valid_nxt = 1'b0;
          end else begin
            pix_nxt = in_pix;
            if (scale_valid_r) begin
              state_nxt = ST_MUL;
            end else if (high_r > low_r) begin
              state_nxt = ST_DIV;
            end else begin
              // Flat or unmeasured image: no scale exists.
              scale_nxt       = '0;
              scale_valid_nxt = 1'b1;
              state_nxt       = ST_MUL;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          scale_nxt       = div_quo;
          scale_valid_nxt = 1'b1;
          state_nxt       = ST_MUL;
        end
      end
      ST_MUL: begin
        below_nxt = pix_r < low_r;
        prod_nxt  = PROD_W'(diff) * PROD_W'(scale_r);
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_err_nxt    = (scale_r == '0);
          out_pix_nxt    = (scale_r == '0) ? '0 : mapped;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      low_r         <= {PIXEL_BITS{1'b1}};
      high_r        <= '0;
      scale_r       <= '0;
      scale_valid_r <= 1'b0;
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      low_r         <= low_nxt;
      high_r        <= high_nxt;
      scale_r       <= scale_nxt;
      scale_valid_r <= scale_valid_nxt;
      out_tvalid_r  <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r     <= pix_nxt;
    prod_r    <= prod_nxt;
    below_r   <= below_nxt;
    out_pix_r <= out_pix_nxt;
    out_err_r <= out_err_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = TDATA_W'(out_pix_r);
  assign out_tuser  = out_err_r;

`ifndef SYNTHESIS
  a_measure_clears_scale: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd == CMD_MEASURE) |=> !scale_valid_r)
    else $error("scale still valid after a measured item");
  a_frame_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd == CMD_MEASURE && in_start) |=> low_r == high_r)
    else $error("frame start did not load minimum and maximum");
  a_div_no_scale: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> !scale_valid_r && div_stat.busy || div_stat.done)
    else $error("dividing while a scale is latched or the divider is idle");
  a_mul_has_scale: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL || state_r == ST_OUT) |-> scale_valid_r)
    else $error("mapping without a latched scale");
  a_error_output_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_err_r) |-> out_pix_r == '0)
    else $error("range error result carries a nonzero pixel");
`endif

endmodule

[tb/sv/stretch_checker.sv]
// Checker for the min/max contrast stretch block: it mirrors the running minimum, maximum
// and latched scale, works out each stretched pixel and compares it with the result channel.
// Depends on mmcs_pkg for the item kinds.
module stretch_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // pixel
  input  logic [1:0] in_tuser,   // cmd, frame_start
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // pixel_out
  input  logic       out_tuser,  // range_error
  output int         fail_count,
  output int         pending
);
  import mmcs_pkg::*;

  localparam int PIX_MAX  = 255;
  localparam int PIX_SPAN = 256;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       range_error;
  } stretch_result_t;

  // Mirrored state of the block.
  logic [7:0] run_min = 8'hFF;
  logic [7:0] run_max = 8'h00;
  logic [8:0] scale = 9'd0;
  logic       scale_held = 1'b0;

  stretch_result_t stretched_q[$];
  int errs = 0;

  // Map one pixel; the first map item after a measurement latches a fresh scale.
  function automatic stretch_result_t stretch_pixel(input logic [7:0] pix);
    stretch_result_t res;
    int span;
    int level;
    if (!scale_held) begin
      span = int'(run_max) - int'(run_min);
      scale = (span > 0) ? 9'(PIX_SPAN / span) : 9'd0;
      scale_held = 1'b1;
    end
    res.range_error = (scale == 9'd0);
    if (scale == 9'd0 || pix < run_min) begin
      res.pixel_out = 8'd0;
    end else begin
      level = (int'(pix) - int'(run_min)) * int'(scale);
      res.pixel_out = (level > PIX_MAX) ? 8'(PIX_MAX) : 8'(level);
    end
    return res;
  endfunction

  // Compare results first, then take the new input item, both at the same edge.
  always @(posedge clk) begin
    stretch_result_t want;
    if (!rst_n) begin
      run_min = 8'hFF;
      run_max = 8'h00;
      scale = 9'd0;
      scale_held = 1'b0;
      stretched_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (stretched_q.size() == 0) begin
          errs++;
          $display("%0t: result with nothing expected: pixel_out %0d range_error %0b",
                   $time, out_tdata, out_tuser);
        end else begin
          want = stretched_q.pop_front();
          if (out_tdata !== want.pixel_out) begin
            errs++;
            $display("%0t: pixel_out expected %0d, got %0d", $time, want.pixel_out, out_tdata);
          end
          if (out_tuser !== want.range_error) begin
            errs++;
            $display("%0t: range_error expected %0b, got %0b", $time, want.range_error,
                     out_tuser);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == CMD_MEASURE) begin
          if (in_tuser[1]) begin
            run_min = in_tdata;
            run_max = in_tdata;
          end else begin
            if (in_tdata < run_min) run_min = in_tdata;
            if (in_tdata > run_max) run_max = in_tdata;
          end
          scale_held = 1'b0;
        end else begin
          stretched_q.push_back(stretch_pixel(in_tdata));
        end
      end
    end
    fail_count <= errs;
    pending <= stretched_q.size();
  end

endmodule

[tb/sv/testbench.sv]
// Top of the contrast stretch testbench: clock, reset, item stimulus and the final verdict.
// Instantiates min_max_contrast_stretch_unit and stretch_checker; uses mmcs_pkg item kinds.
module testbench;
  import mmcs_pkg::*;

  localparam int ITEM_TARGET = 1600;
  localparam int CYCLE_LIMIT = 400000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'd0;   // pixel
  logic [1:0] in_tuser = 2'd0;   // cmd, frame_start
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;         // pixel_out
  logic       out_tuser;         // range_error

  int fail_count;
  int pending;
  int sent = 0;
  int cycles = 0;
  logic sender_gaps = 1'b1;
  logic receiver_gaps = 1'b1;

  min_max_contrast_stretch_unit #(.PIXEL_BITS(8)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  stretch_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // The receiver stalls at random unless the quiet stretch is on.
  always @(negedge clk) begin
    out_tready <= !receiver_gaps || ($urandom_range(99) >= 12);
  end

  // Present one item and hold it until the block takes it.
  task automatic send_pixel(input logic cmd, input logic fs, input logic [7:0] pix);
    while (sender_gaps && $urandom_range(99) < 12) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = {fs, cmd};
    in_tdata = pix;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  // Hold off the sender until every stretched pixel has come back.
  task automatic drain();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Pixel from a window of the grey scale, clipped at white.
  function automatic logic [7:0] window_pixel(input int base, input int spread);
    int v;
    v = base + $urandom_range(spread);
    return (v > 255) ? 8'd255 : 8'(v);
  endfunction

  // One measure pass and one map pass; a few frames are deliberately malformed.
  task automatic random_frame();
    int n_meas;
    int n_map;
    int base;
    int spread;
    int mode;
    int broken;
    logic fs;
    n_meas = $urandom_range(1, 12);
    n_map = $urandom_range(1, 12);
    base = $urandom_range(255);
    mode = $urandom_range(99);
    if (mode < 8) spread = 0;
    else if (mode < 30) spread = $urandom_range(1, 8);
    else if (mode < 45) begin
      base = 0;
      spread = 255;
    end else spread = $urandom_range(255);
    broken = ($urandom_range(99) < 15) ? $urandom_range(1, 4) : 0;
    if (broken == 1) n_meas = 0;
    for (int i = 0; i < n_meas; i++) begin
      fs = (i == 0) ? (broken != 2) : ($urandom_range(99) < 3);
      send_pixel(CMD_MEASURE, fs, window_pixel(base, spread));
    end
    for (int i = 0; i < n_map; i++) begin
      // A stray measurement in the middle of the map pass forces a new scale.
      if (broken == 3 && i == n_map / 2)
        send_pixel(CMD_MEASURE, 1'b0, 8'($urandom_range(255)));
      fs = (broken == 4) ? 1'($urandom_range(1)) : 1'b0;
      if ($urandom_range(1) == 1) send_pixel(CMD_MAP, fs, 8'($urandom_range(255)));
      else send_pixel(CMD_MAP, fs, window_pixel(base, spread));
    end
  endtask

  initial begin
    int frame;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Nothing measured yet: treated as a flat image.
    send_pixel(CMD_MAP, 1'b0, 8'd0);
    send_pixel(CMD_MAP, 1'b1, 8'd255);
    // Flat image.
    send_pixel(CMD_MEASURE, 1'b1, 8'd100);
    send_pixel(CMD_MEASURE, 1'b0, 8'd100);
    send_pixel(CMD_MAP, 1'b0, 8'd100);
    // Full range gives a scale of one.
    send_pixel(CMD_MEASURE, 1'b1, 8'd0);
    send_pixel(CMD_MEASURE, 1'b0, 8'd255);
    send_pixel(CMD_MAP, 1'b0, 8'd0);
    send_pixel(CMD_MAP, 1'b0, 8'd255);
    send_pixel(CMD_MAP, 1'b0, 8'd128);
    // Narrow range: below the minimum, in range, and saturated; frame start is ignored in map.
    send_pixel(CMD_MEASURE, 1'b1, 8'd50);
    send_pixel(CMD_MEASURE, 1'b0, 8'd60);
    send_pixel(CMD_MAP, 1'b0, 8'd40);
    send_pixel(CMD_MAP, 1'b0, 8'd55);
    send_pixel(CMD_MAP, 1'b0, 8'd70);
    send_pixel(CMD_MAP, 1'b1, 8'd60);
    // Measurements after a map pass, including a new minimum.
    send_pixel(CMD_MEASURE, 1'b0, 8'd52);
    send_pixel(CMD_MAP, 1'b0, 8'd51);
    send_pixel(CMD_MEASURE, 1'b0, 8'd0);
    send_pixel(CMD_MAP, 1'b0, 8'd10);
    // Range of one: the largest scale.
    send_pixel(CMD_MEASURE, 1'b1, 8'd254);
    send_pixel(CMD_MEASURE, 1'b0, 8'd255);
    send_pixel(CMD_MAP, 1'b0, 8'd255);
    send_pixel(CMD_MAP, 1'b0, 8'd254);
    drain();

    frame = 0;
    while (sent < ITEM_TARGET) begin
      // A long quiet stretch where neither side idles.
      sender_gaps = !(frame >= 60 && frame < 100);
      receiver_gaps = sender_gaps;
      random_frame();
      if (frame % 20 == 19) drain();
      frame++;
    end
    in_tvalid = 1'b0;
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;

    drain();
    repeat (30) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
